// ===== rtl/core/masked_byte_pattern_search_assert.svh =====
// Assertion macros shared by the masked byte pattern search RTL.
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, ignored while reset is asserted
`define MBPS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define MBPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBPS_ASSERT(label, clk, rstn, prop, msg)
`define MBPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/mbps_pkg.sv =====
// Package: types and constants of the masked byte pattern search.
`timescale 1ns / 1ps

package mbps_pkg;

    // Fixed geometry of the pattern registers and the byte window
    localparam int PATTERN_MAX_DEF = 16;
    localparam int WINDOW_DEPTH    = 16;
    localparam int PAT_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int ADDR_W          = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_REGION_BASE    = 3'd4
    } cfg_reg_t;

    // Pattern setup seen by every cell
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] bytes;
        logic [PAT_BYTES-1:0]      care;
        logic [LEN_W-1:0]          len;
    } pat_cfg_t;

    // Per-cycle control of the cell row
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/mbps_cell.sv =====
// One window cell: holds one byte and checks the byte it takes in against its pattern byte.
`timescale 1ns / 1ps

module mbps_cell
    import mbps_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  pat_cfg_t   pat,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic [LEN_W-1:0] k_full;
    logic [3:0]       k;
    logic             in_use;

    // Pattern position that lines up with this cell: len - 1 - IDX
    assign in_use = LEN_W'(IDX) < pat.len;
    assign k_full = pat.len - LEN_W'(IDX) - LEN_W'(1);
    assign k      = k_full[3:0];

    // Compare the byte entering this cell; unused or wildcard positions pass
    assign hit = !in_use || !pat.care[k] || (byte_in == pat.bytes[k]);

    // Shift in from the neighbor, drop the window at region end
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== rtl/core/masked_byte_pattern_search.sv =====
// Top level: masked byte pattern search over a streamed region.
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_assert.svh"

// Takes one region byte per cycle while s_ready is high and reports the first
// place where the configured pattern (up to 16 bytes, clear care bits are
// wildcards) matches entirely inside the region: found with region_base plus
// the start offset, or, on the last byte without a match, not found with
// address 0. Exactly one result per region. The byte window is a row of
// cells, one per pattern position, each checking the byte entering it in
// parallel in the cycle it is taken, so the block sustains one byte per clock
// while s_ready holds; a result appears on the m_ side in the cycle after the
// byte that caused it. A single output register holds the result, and input
// is taken whenever that register is empty or is being drained in the same
// cycle. No clearing pass follows reset. Configuration writes are applied at
// once and must be made while no region is in flight.
module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // byte stream
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_scan_byte,
    input  logic                   s_last_byte,
    // result
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [ADDR_W-1:0]      m_match_address
);

    localparam int CELLS = (PATTERN_MAX < WINDOW_DEPTH) ? PATTERN_MAX : WINDOW_DEPTH;

    // Configuration registers
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [PAT_BYTES-1:0]  care_mask_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [ADDR_W-1:0]     region_base_reg;

    // Scan state and output register
    logic [ADDR_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic              reported_reg, reported_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;

    logic              accept;
    logic [LEN_W-1:0]  len_used;
    logic [ADDR_W-1:0] seen_inc;
    logic              hit_now;
    logic              emit;
    pat_cfg_t          pat;
    cell_ctrl_t        ctrl;
    logic [7:0]        chain [CELLS+1];
    logic [CELLS-1:0]  hit_vec;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= LEN_W'(1);
            region_base_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                CFG_CARE_MASK:      care_mask_reg      <= cfg_wdata[PAT_BYTES-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_REGION_BASE:    region_base_reg    <= cfg_wdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the pattern length to the number of cells
    assign len_used = (pattern_length_reg > LEN_W'(CELLS)) ? LEN_W'(CELLS)
                                                          : pattern_length_reg;

    assign pat.bytes = {pattern_high_reg, pattern_low_reg};
    assign pat.care  = care_mask_reg;
    assign pat.len   = len_used;

    // Handshake: take a byte when the result slot is free or draining
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign ctrl.shift = accept;
    assign ctrl.clear = accept && s_last_byte;

    // Row of window cells, newest byte enters cell 0
    assign chain[0] = s_scan_byte;
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        mbps_cell #(
            .IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .pat      (pat),
            .byte_in  (chain[i]),
            .byte_out (chain[i+1]),
            .hit      (hit_vec[i])
        );
    end

    // Saturating byte count including the incoming byte
    assign seen_inc = (bytes_seen_reg == '1) ? bytes_seen_reg : bytes_seen_reg + ADDR_W'(1);

    // First match fully inside the region
    assign hit_now = !reported_reg && (seen_inc >= ADDR_W'(len_used)) && (&hit_vec);
    assign emit    = accept && (hit_now || (s_last_byte && !reported_reg));

    // Advance scan state, reset it at region end
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        if (accept) begin
            if (s_last_byte) begin
                bytes_seen_next = '0;
                reported_next   = 1'b0;
            end else begin
                bytes_seen_next = seen_inc;
                reported_next   = reported_reg || hit_now;
            end
        end
    end

    // Load or drain the result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_addr_next  = m_addr_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_found_next = hit_now;
            m_addr_next  = hit_now ? (region_base_reg + seen_inc - ADDR_W'(len_used)) : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_addr_reg  <= m_addr_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_addr_reg;

    // Checks
    `MBPS_ASSERT(a_emit_shows, aclk, aresetn, emit |=> m_valid,
        "result lost after emit")
    `MBPS_ASSERT(a_region_end_clears, aclk, aresetn,
        (accept && s_last_byte) |=> (bytes_seen_reg == '0 && !reported_reg),
        "scan state not cleared at region end")
    `MBPS_ASSERT(a_match_marks, aclk, aresetn,
        (accept && hit_now && !s_last_byte) |=> reported_reg,
        "match not marked as reported")
    `MBPS_ASSERT(a_count_saturates, aclk, aresetn,
        (accept && !s_last_byte && bytes_seen_reg == '1) |=> (bytes_seen_reg == '1),
        "byte count wrapped")
    `MBPS_ASSERT(a_not_found_zero, aclk, aresetn,
        (m_valid && !m_found) |-> (m_match_address == '0),
        "not found result with nonzero address")

endmodule

// ===== dv/masked_byte_pattern_search_tb.sv =====
// Testbench for the masked byte pattern search: directed and random regions, scoreboard check.
`timescale 1ns / 1ps

module masked_byte_pattern_search_tb;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int STREAM_GOAL = 560;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } scan_outcome_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_scan_byte = '0;
    logic                   s_last_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_found;
    logic [ADDR_W-1:0]      m_match_address;

    // Bytes waiting to be offered, and outcomes waiting to come back
    stream_byte_t  byte_stream[$];
    scan_outcome_t expected_outcomes[$];

    // Shadow of the configuration registers
    logic [63:0]       pat_lo = '0;
    logic [63:0]       pat_hi = '0;
    logic [15:0]       care = '0;
    logic [LEN_W-1:0]  plen = LEN_W'(1);
    logic [ADDR_W-1:0] base = '0;

    // Shadow of the scan state
    logic [WINDOW_DEPTH-1:0][7:0] scan_window = '0;
    logic [31:0]                  scan_count = '0;
    logic                         scan_reported = 1'b0;

    int  mismatches = 0;
    int  bytes_queued = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  ready_left = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;

    masked_byte_pattern_search i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_scan_byte     (s_scan_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_match_address (m_match_address)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("masked_byte_pattern_search_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] pattern_byte(input int k);
        return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
    endfunction

    // Advance the scan state by one byte and queue any outcome it causes
    task automatic predict_scan(input logic [7:0] b, input logic last_b);
        int unsigned   used;
        int            k;
        logic          hit;
        scan_outcome_t outcome;
        scan_window = {scan_window[WINDOW_DEPTH-2:0], b};
        if (scan_count != 32'hFFFF_FFFF)
            scan_count = scan_count + 1;
        used = (plen > WINDOW_DEPTH) ? WINDOW_DEPTH : plen;
        if (!scan_reported && scan_count >= used) begin
            hit = 1'b1;
            for (k = 0; k < int'(used); k++) begin
                if (care[k] && scan_window[used-1-k] != pattern_byte(k))
                    hit = 1'b0;
            end
            if (hit) begin
                outcome.found   = 1'b1;
                outcome.address = base + (scan_count - used);
                expected_outcomes.push_back(outcome);
                scan_reported = 1'b1;
            end
        end
        // Region end: report a miss if nothing was found, then start over
        if (last_b) begin
            if (!scan_reported) begin
                outcome = '0;
                expected_outcomes.push_back(outcome);
            end
            scan_window   = '0;
            scan_count    = '0;
            scan_reported = 1'b0;
        end
    endtask

    // Drive the byte stream; draw a gap for each byte offered
    always @(posedge aclk) begin : drive_stream
        stream_byte_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_scan(s_scan_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (byte_stream.size() != 0) begin
                    nxt = byte_stream.pop_front();
                    s_valid     <= 1'b1;
                    s_scan_byte <= nxt.data;
                    s_last_byte <= nxt.last;
                    gap_left    <= send_idle ? int'($urandom_range(0, 13)) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer; stall the result side per result and now and then for long
    always @(posedge aclk) begin : check_results
        scan_outcome_t want;
        int            wait_n;
        int            hold_n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
            hold_left  <= 0;
        end else begin
            wait_n = ready_left;
            hold_n = hold_left;
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result found=%0b address=%h with none expected",
                                              m_found, m_match_address));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  m_found, want.found));
                    if (m_match_address !== want.address)
                        report_mismatch($sformatf("match_address %h, expected %h",
                                                  m_match_address, want.address));
                end
                wait_n = recv_idle ? int'($urandom_range(0, 13)) : 0;
                if (holds_done < 3 && byte_stream.size() >= 10) begin
                    hold_n = LONG_HOLD;
                    holds_done++;
                end
            end else begin
                if (wait_n != 0)
                    wait_n--;
                if (hold_n != 0)
                    hold_n--;
            end
            ready_left <= wait_n;
            hold_left  <= hold_n;
            m_ready    <= (wait_n == 0) && (hold_n == 0);
        end
    end

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_PATTERN_LOW:    pat_lo = v;
            CFG_PATTERN_HIGH:   pat_hi = v;
            CFG_CARE_MASK:      care   = v[15:0];
            CFG_PATTERN_LENGTH: plen   = v[LEN_W-1:0];
            CFG_REGION_BASE:    base   = v[ADDR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last_b);
        stream_byte_t item;
        item.data = b;
        item.last = last_b;
        byte_stream.push_back(item);
        bytes_queued++;
    endtask

    // Hold until every byte is taken and every outcome returned, then let the block settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (byte_stream.size() != 0 || s_valid || expected_outcomes.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Build one region: embed the pattern, embed it with one cared bit flipped, or fill at random
    task automatic queue_region(input int rlen, input int mode);
        logic [7:0] bytes_buf [0:63];
        int         ulen;
        int         at;
        int         k;
        int         tries;
        for (k = 0; k < rlen; k++)
            bytes_buf[k] = 8'($urandom_range(0, 255));
        ulen = (plen > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(plen);
        if (mode != 2 && ulen != 0 && ulen <= rlen) begin
            at = $urandom_range(0, rlen - ulen);
            for (k = 0; k < ulen; k++) begin
                if (care[k])
                    bytes_buf[at+k] = pattern_byte(k);
            end
            if (mode == 1) begin
                for (tries = 0; tries < 16; tries++) begin
                    k = $urandom_range(0, ulen - 1);
                    if (care[k]) begin
                        bytes_buf[at+k][$urandom_range(0, 7)] ^= 1'b1;
                        break;
                    end
                end
            end
        end
        for (k = 0; k < rlen; k++)
            push_byte(bytes_buf[k], k == rlen - 1);
    endtask

    task automatic random_config();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        cfg_write(CFG_PATTERN_LOW, v);
        v = ($urandom_range(0, 5) == 0) ? '1 : {$urandom, $urandom};
        cfg_write(CFG_PATTERN_HIGH, v);
        // Upper bits beyond the register are written as noise now and then
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        case ($urandom_range(0, 5))
            0:       v[15:0] = '0;
            1:       v[15:0] = '1;
            default: v[15:0] = 16'($urandom);
        endcase
        cfg_write(CFG_CARE_MASK, v);
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        case ($urandom_range(0, 9))
            0:       v[4:0] = 5'd0;
            1:       v[4:0] = 5'd16;
            2:       v[4:0] = 5'($urandom_range(17, 31));
            default: v[4:0] = 5'($urandom_range(1, 16));
        endcase
        cfg_write(CFG_PATTERN_LENGTH, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = {32'h0, 32'hFFFF_FFFF};
            default: v = {$urandom, $urandom};
        endcase
        cfg_write(CFG_REGION_BASE, v);
    endtask

    initial begin : run_test
        int k;
        int nreg;
        int rlen;
        int sel;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setup: one-byte wildcard pattern hits on the first byte
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // Length above the window saturates to 16; match on the final byte; base at the top
        cfg_write(CFG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_PATTERN_HIGH, 64'hFF00_807F_01FE_5AA5);
        cfg_write(CFG_CARE_MASK, 64'hFFFF);
        cfg_write(CFG_PATTERN_LENGTH, 64'd31);
        cfg_write(CFG_REGION_BASE, 64'hFFFF_FFFF);
        for (k = 0; k < 16; k++)
            push_byte(pattern_byte(k), k == 15);
        wait_idle();

        // Wildcard in the middle, address wraps, bytes after the hit give nothing
        cfg_write(CFG_CARE_MASK, 64'hB);
        cfg_write(CFG_PATTERN_LENGTH, 64'd4);
        cfg_write(CFG_REGION_BASE, 64'hFFFF_FFFE);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(pattern_byte(0), 1'b0);
        push_byte(pattern_byte(1), 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(pattern_byte(3), 1'b0);
        push_byte(8'h77, 1'b1);
        wait_idle();
        // Region shorter than the pattern never matches
        cfg_write(CFG_CARE_MASK, 64'h0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b1);
        wait_idle();

        // Empty pattern
        cfg_write(CFG_PATTERN_LENGTH, 64'd0);
        push_byte(8'h42, 1'b1);
        wait_idle();

        // Back-to-back short regions, each a hit, to fill the block under a long stall
        cfg_write(CFG_PATTERN_LENGTH, 64'd1);
        send_idle = 1'b0;
        for (k = 0; k < 30; k++)
            queue_region($urandom_range(1, 3), 2);
        wait_idle();

        // Random phases
        while (bytes_queued < STREAM_GOAL) begin
            random_config();
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            nreg = $urandom_range(2, 8);
            for (k = 0; k < nreg; k++) begin
                rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16);
                sel = $urandom_range(0, 9);
                queue_region(rlen, (sel < 6) ? 0 : (sel < 8) ? 1 : 2);
            end
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        if (expected_outcomes.size() != 0)
            report_mismatch($sformatf("%0d outcomes never arrived", expected_outcomes.size()));
        if (mismatches == 0)
            $display("masked_byte_pattern_search_tb: PASS");
        else
            $display("masked_byte_pattern_search_tb: FAIL");
        $finish;
    end

endmodule
